FILE: rtl/sbbl_pkg.sv
// ----------------------------------------------------------------------------
// sbbl_pkg
// Shared types and constants of the horizontal box blur line filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbl_pkg;

  localparam int ChanW        = 8;     // bits per color channel
  localparam int CfgW         = 5;     // width of the radius register
  localparam int PixW         = 4 * ChanW;
  localparam int PosMaxW      = 13;    // position field, fits the largest row
  localparam int RadMaxW      = 6;     // radius field, fits the largest radius
  localparam int MaxRadiusDef = 25;
  localparam int MaxRowDef    = 4096;
  localparam int QueueDepth   = 2;

  typedef struct packed {
    logic [ChanW-1:0] pix_alpha;
    logic [ChanW-1:0] pix_red;
    logic [ChanW-1:0] pix_green;
    logic [ChanW-1:0] pix_blue;
    logic             row_end;
  } pix_t;

  typedef struct packed {
    logic [ChanW-1:0] avg_alpha;
    logic [ChanW-1:0] avg_red;
    logic [ChanW-1:0] avg_green;
    logic [ChanW-1:0] avg_blue;
    logic             row_done;
  } res_t;

  // One classified pixel, handed from the front to the back.
  typedef struct packed {
    logic [PixW-1:0]    pixel;    // A,R,G,B from high byte to low byte
    logic [PosMaxW-1:0] pos;      // position within the row
    logic [RadMaxW-1:0] radius;   // radius latched for this row
    logic               row_end;  // last pixel of the row, forced or flagged
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/sbbl_ram.sv
// ----------------------------------------------------------------------------
// sbbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbl_ram #(
  parameter int Width = 32,
  parameter int Depth = 51
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/sbbl_front.sv
// ----------------------------------------------------------------------------
// sbbl_front
// Accept pixels, track the row position, latch the radius per row.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbl_front #(
  parameter int MaxRadius    = sbbl_pkg::MaxRadiusDef,
  parameter int MaxRowPixels = sbbl_pkg::MaxRowDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [sbbl_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire sbbl_pkg::pix_t            pix_i,
  input  wire logic                      pix_valid_i,
  output      logic                      pix_ready_o,
  output      sbbl_pkg::entry_t          entry_o,
  output      logic                      entry_valid_o,
  input  wire logic                      entry_ready_i
);

  localparam int PosW = $clog2(MaxRowPixels);
  localparam int RadW = $clog2(MaxRadius + 1);

  logic [sbbl_pkg::CfgW-1:0] blur_q;
  logic [PosW-1:0]           pos_q, pos_d;
  logic [RadW-1:0]           rowr_q, rowr_d;
  logic [RadW-1:0]           eff_rad, use_rad;
  logic                      last_pix, push;

  // Clamp the register into the usable radius range.
  always_comb begin
    priority if (blur_q == '0) begin
      eff_rad = RadW'(1);
    end else if (int'(blur_q) > MaxRadius) begin
      eff_rad = RadW'(MaxRadius);
    end else begin
      eff_rad = RadW'(blur_q);
    end
  end

  assign use_rad  = (pos_q == '0) ? eff_rad : rowr_q;
  assign last_pix = pix_i.row_end || (pos_q == PosW'(MaxRowPixels - 1));

  assign pix_ready_o   = entry_ready_i;
  assign entry_valid_o = pix_valid_i;
  assign push          = pix_valid_i && entry_ready_i;

  assign entry_o.pixel   = {pix_i.pix_alpha, pix_i.pix_red, pix_i.pix_green, pix_i.pix_blue};
  assign entry_o.pos     = sbbl_pkg::PosMaxW'(pos_q);
  assign entry_o.radius  = sbbl_pkg::RadMaxW'(use_rad);
  assign entry_o.row_end = last_pix;

  always_comb begin
    pos_d  = pos_q;
    rowr_d = rowr_q;
    if (push) begin
      rowr_d = use_rad;
      pos_d  = last_pix ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur_q <= sbbl_pkg::CfgW'(1);
      pos_q  <= '0;
      rowr_q <= RadW'(1);
    end else begin
      if (cfg_we_i) begin
        blur_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      rowr_q <= rowr_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sbbl_fifo.sv
// ----------------------------------------------------------------------------
// sbbl_fifo
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbl_fifo #(
  parameter int Depth = sbbl_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sbbl_pkg::entry_t data_i,
  input  wire logic             valid_i,
  output      logic             ready_o,
  output      sbbl_pkg::entry_t data_o,
  output      logic             valid_o,
  input  wire logic             ready_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  sbbl_pkg::entry_t store_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = store_q[rptr_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sbbl_back.sv
// ----------------------------------------------------------------------------
// sbbl_back
// Store pixels in the window RAM, sweep each output window, divide, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbl_back #(
  parameter int MaxRadius    = sbbl_pkg::MaxRadiusDef,
  parameter int MaxRowPixels = sbbl_pkg::MaxRowDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sbbl_pkg::entry_t entry_i,
  input  wire logic             entry_valid_i,
  output      logic             entry_ready_o,
  output      sbbl_pkg::res_t   res_o,
  output      logic             res_valid_o,
  input  wire logic             res_ready_i
);

  localparam int ChanW    = sbbl_pkg::ChanW;
  localparam int WinDepth = 2 * MaxRadius + 1;
  localparam int AW       = $clog2(WinDepth);
  localparam int PosW     = $clog2(MaxRowPixels);
  localparam int RadW     = $clog2(MaxRadius + 1);
  localparam int IW       = ((PosW > RadW) ? PosW : RadW) + 2;
  localparam int CntW     = $clog2(2 * MaxRadius + 2);
  localparam int SumW     = $clog2(WinDepth * 255 + 1);
  localparam int StepW    = $clog2(ChanW);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StWrite = 6'b000010,
    StSetup = 6'b000100,
    StAccum = 6'b001000,
    StDiv   = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [sbbl_pkg::PixW-1:0] px_q, px_d;
  logic [PosW-1:0]         p_q, p_d, x_q, x_d, xlast_q, xlast_d;
  logic [RadW-1:0]         r_q, r_d;
  logic                    end_q, end_d;
  logic [AW-1:0]           wa_q, wa_d, a_q, a_d;
  logic signed [IW-1:0]    i_q, i_d;
  logic [CntW-1:0]         left_q, left_d;
  logic                    rdv_q, rdv_d;
  logic [StepW-1:0]        step_q, step_d;
  logic [SumW-1:0]         sum_q [4];
  logic [SumW-1:0]         sum_d [4];
  logic [CntW-1:0]         rem_q [4];
  logic [CntW-1:0]         rem_d [4];
  logic [ChanW-1:0]        quo_q [4];
  logic [ChanW-1:0]        quo_d [4];
  sbbl_pkg::res_t          res_q, res_d;
  logic                    res_valid_q, res_valid_d;

  logic [CntW-1:0]         cnt;
  logic [PosW-1:0]         r_pos;
  logic signed [IW-1:0]    lo_s, p_s, d_s;
  logic [AW-1:0]           d_a, start_a, a_inc, wa_inc;
  logic [AW:0]             wrap_sum;
  logic [CntW:0]           trial [4];
  logic                    ge [4];
  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [sbbl_pkg::PixW-1:0] ram_rdata;

  assign cnt      = CntW'({r_q, 1'b1});
  assign r_pos    = PosW'(r_q);
  assign p_s      = signed'(IW'(p_q));
  assign lo_s     = signed'(IW'(x_q)) - signed'(IW'(r_q));
  assign d_s      = p_s - lo_s;
  assign d_a      = AW'(d_s);
  assign wrap_sum = (AW+1)'(wa_q) + (AW+1)'(WinDepth) - (AW+1)'(d_a);
  assign start_a  = (wa_q >= d_a) ? wa_q - d_a : AW'(wrap_sum);
  assign a_inc    = (a_q == AW'(WinDepth - 1)) ? '0 : a_q + 1'b1;
  assign wa_inc   = (wa_q == AW'(WinDepth - 1)) ? '0 : wa_q + 1'b1;

  // Past the newest pixel the window clamps to it.
  assign ram_raddr = (i_q > p_s) ? wa_q : a_q;

  sbbl_ram #(
    .Width (sbbl_pkg::PixW),
    .Depth (WinDepth)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_q),
    .wdata_i (px_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One restoring division step per channel.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      trial[k] = {rem_q[k], quo_q[k][ChanW-1]};
      ge[k]    = (trial[k] >= (CntW+1)'(cnt));
    end
  end

  always_comb begin
    state_d       = state_q;
    px_d          = px_q;
    p_d           = p_q;
    r_d           = r_q;
    end_d         = end_q;
    x_d           = x_q;
    xlast_d       = xlast_q;
    wa_d          = wa_q;
    a_d           = a_q;
    i_d           = i_q;
    left_d        = left_q;
    rdv_d         = rdv_q;
    step_d        = step_q;
    sum_d         = sum_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    res_d         = res_q;
    res_valid_d   = res_valid_q && !res_ready_i;
    ram_we        = 1'b0;
    entry_ready_o = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (entry_valid_i) begin
          entry_ready_o = 1'b1;
          px_d          = entry_i.pixel;
          p_d           = PosW'(entry_i.pos);
          r_d           = RadW'(entry_i.radius);
          end_d         = entry_i.row_end;
          state_d       = StWrite;
        end
      end
      StWrite: begin
        ram_we = 1'b1;
        if (end_q) begin
          x_d     = (p_q >= r_pos) ? p_q - r_pos : '0;
          xlast_d = p_q;
          state_d = StSetup;
        end else if (p_q >= r_pos) begin
          x_d     = p_q - r_pos;
          xlast_d = p_q - r_pos;
          state_d = StSetup;
        end else begin
          wa_d    = wa_inc;
          state_d = StIdle;
        end
      end
      StSetup: begin
        i_d    = lo_s;
        a_d    = (lo_s < 0) ? '0 : start_a;
        left_d = cnt;
        rdv_d  = 1'b0;
        for (int k = 0; k < 4; k++) begin
          sum_d[k] = '0;
        end
        state_d = StAccum;
      end
      StAccum: begin
        rdv_d = (left_q != '0);
        if (left_q != '0) begin
          left_d = left_q - 1'b1;
          i_d    = i_q + 1'b1;
          if ((i_q >= 0) && (i_q < p_s)) begin
            a_d = a_inc;
          end
        end
        if (rdv_q) begin
          for (int k = 0; k < 4; k++) begin
            sum_d[k] = sum_q[k] + SumW'(ram_rdata[sbbl_pkg::PixW-1-ChanW*k -: ChanW]);
          end
        end
        if ((left_q == '0) && !rdv_q) begin
          for (int k = 0; k < 4; k++) begin
            rem_d[k] = CntW'(sum_q[k] >> ChanW);
            quo_d[k] = sum_q[k][ChanW-1:0];
          end
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        for (int k = 0; k < 4; k++) begin
          rem_d[k] = ge[k] ? CntW'(trial[k] - (CntW+1)'(cnt)) : CntW'(trial[k]);
          quo_d[k] = {quo_q[k][ChanW-2:0], ge[k]};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(ChanW - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!res_valid_q || res_ready_i) begin
          res_d.avg_alpha = quo_q[0];
          res_d.avg_red   = quo_q[1];
          res_d.avg_green = quo_q[2];
          res_d.avg_blue  = quo_q[3];
          res_d.row_done  = end_q && (x_q == p_q);
          res_valid_d     = 1'b1;
          if (x_q == xlast_q) begin
            wa_d    = end_q ? '0 : wa_inc;
            state_d = StIdle;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = StSetup;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    p_q     <= p_d;
    r_q     <= r_d;
    end_q   <= end_d;
    x_q     <= x_d;
    xlast_q <= xlast_d;
    a_q     <= a_d;
    i_q     <= i_d;
    step_q  <= step_d;
    sum_q   <= sum_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wa_q        <= '0;
      left_q      <= '0;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wa_q        <= wa_d;
      left_q      <= left_d;
      rdv_q       <= rdv_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

FILE: rtl/sliding_box_blur_line.sv
// ----------------------------------------------------------------------------
// sliding_box_blur_line
// Horizontal box blur over one row of ARGB pixels, edges clamped.
// ----------------------------------------------------------------------------
// Pixels of a row come in one request at a time, the last one flagged with
// row_end (a row that reaches MaxRowPixels ends there on its own). For each
// position x the block returns, per channel, the truncated mean over the
// window x-r..x+r, using the first pixel for positions before the row and
// the last pixel for positions past it. Results trail the input by r pixels;
// the last pixel of a row releases the remaining ones, the final one marked
// with row_done. The radius r is taken from the config register when the
// first pixel of a row arrives (0 acts as 1, values above MaxRadius act as
// MaxRadius), so a write shows from the next row on. The back end first picks
// up a pixel and then stores it in the window RAM; every result that pixel
// releases is computed by a sweep of the 2r+1 window entries through the
// single read port of the window RAM and an 8-step divider per channel.
// A two-entry queue lets the front take pixels while the back still works,
// and a result register lets the back go on while a result waits
// downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_box_blur_line #(
  parameter int MaxRadius    = sbbl_pkg::MaxRadiusDef,
  parameter int MaxRowPixels = sbbl_pkg::MaxRowDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // radius register write
  input  wire logic                      cfg_we_i,
  input  wire logic [sbbl_pkg::CfgW-1:0] cfg_wdata_i,
  // pixel requests
  input  wire sbbl_pkg::pix_t            pix_i,
  input  wire logic                      pix_valid_i,
  output      logic                      pix_ready_o,
  // result requests
  output      sbbl_pkg::res_t            res_o,
  output      logic                      res_valid_o,
  input  wire logic                      res_ready_i
);

  sbbl_pkg::entry_t fr_entry, bk_entry;
  logic             fr_valid, fr_ready;
  logic             bk_valid, bk_ready;

  // Front: classify each pixel (position, row radius, row end).
  sbbl_front #(
    .MaxRadius    (MaxRadius),
    .MaxRowPixels (MaxRowPixels)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pix_i         (pix_i),
    .pix_valid_i   (pix_valid_i),
    .pix_ready_o   (pix_ready_o),
    .entry_o       (fr_entry),
    .entry_valid_o (fr_valid),
    .entry_ready_i (fr_ready)
  );

  // Queue: decouple the accepting side from the window sweep.
  sbbl_fifo #(
    .Depth (sbbl_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (fr_entry),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_o  (bk_entry),
    .valid_o (bk_valid),
    .ready_i (bk_ready)
  );

  // Back: store the pixel, then compute every result it releases.
  sbbl_back #(
    .MaxRadius    (MaxRadius),
    .MaxRowPixels (MaxRowPixels)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (bk_entry),
    .entry_valid_i (bk_valid),
    .entry_ready_o (bk_ready),
    .res_o         (res_o),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i)
  );

endmodule

`default_nettype wire

FILE: rtl/sbbl_checker.sv
// ----------------------------------------------------------------------------
// sbbl_checker
// Port-level checks of the box blur line, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbl_checker #(
  parameter int MaxRowPixels = sbbl_pkg::MaxRowDef
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire sbbl_pkg::pix_t pix_i,
  input wire logic           pix_valid_i,
  input wire logic           pix_ready_o,
  input wire sbbl_pkg::res_t res_o,
  input wire logic           res_valid_o,
  input wire logic           res_ready_i
);

  localparam int PosW = $clog2(MaxRowPixels);

  logic [15:0]     pend_q;   // pixels taken minus results given
  logic [15:0]     rows_q;   // rows ended minus rows finished
  logic [PosW-1:0] col_q;
  logic            in_acc, out_acc, row_in;

  assign in_acc  = pix_valid_i && pix_ready_o;
  assign out_acc = res_valid_o && res_ready_i;
  assign row_in  = in_acc && (pix_i.row_end || (col_q == PosW'(MaxRowPixels - 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      rows_q <= '0;
      col_q  <= '0;
    end else begin
      pend_q <= pend_q + 16'(in_acc) - 16'(out_acc);
      rows_q <= rows_q + 16'(row_in) - 16'(out_acc && res_o.row_done);
      if (in_acc) begin
        col_q <= row_in ? '0 : col_q + 1'b1;
      end
    end
  end

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result dropped or changed while stalled");

  // Never give more results than pixels taken.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != '0)
    else $error("result without a pending pixel");

  // Close a row only after its last pixel arrived.
  a_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && res_o.row_done |-> rows_q != '0)
    else $error("row_done without an ended row");

endmodule

bind sliding_box_blur_line sbbl_checker #(
  .MaxRowPixels (MaxRowPixels)
) u_sbbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_i       (pix_i),
  .pix_valid_i (pix_valid_i),
  .pix_ready_o (pix_ready_o),
  .res_o       (res_o),
  .res_valid_o (res_valid_o),
  .res_ready_i (res_ready_i)
);

`default_nettype wire
